>>> rtl/core/sm4mac_pkg.sv
// Package: SM4 constants, S-box and round functions for the CBC-MAC unit.
package sm4mac_pkg;

  localparam int unsigned Rounds = 32;
  localparam int unsigned RkAw   = 5;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [4:0]  BlockBytes = 5'h10;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  localparam logic [31:0] FK0 = 32'ha3b1bac6;
  localparam logic [31:0] FK1 = 32'h56aa3350;
  localparam logic [31:0] FK2 = 32'h677d9197;
  localparam logic [31:0] FK3 = 32'hb27022dc;

  function automatic logic [31:0] tau(input logic [31:0] a);
    return {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] round_lin(input logic [31:0] a);
    logic [31:0] b;
    b = tau(a);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] key_lin(input logic [31:0] a);
    logic [31:0] b;
    b = tau(a);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // CK byte j of round i is ((4i+j)*7) mod 256
  function automatic logic [31:0] ck_word(input logic [RkAw-1:0] i);
    logic [7:0] b0;
    b0 = {1'b0, i, 2'b00} * 8'd7;
    return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
  endfunction

  typedef struct packed {
    logic start;   // expand keys first
    logic [127:0] blk;
  } sm4mac_req_t;

endpackage

>>> rtl/core/sm4_cbc_mac_unit.sv
// Top level: SM4 CBC-MAC with padding method 2, stream in/out and APB config.
// Usage:
//   in_*  : one 16-byte block per beat. tdata = {valid_bytes, data_low, data_high}
//           packed from bit 0; tlast marks the message tail (0..16 bytes).
//   out_* : one MAC beat per message, tdata = {mac_low, mac_high}.
//   cfg_* : key_high @0x00, key_low @0x08, iv_high @0x10, iv_low @0x18.
// Throughput: one block at a time. An ordinary block passes through the round
// engine (the accept, a read-ahead of round key 0 and 32 rounds, one round key
// read from the key memory each round) and then a chaining step, and the next
// beat is taken only after that. The first block of a message first runs the
// key schedule, which writes all 32 round keys into the same memory. A full
// 16-byte tail runs the engine twice.
// After the last beat, the MAC is registered in the cycle the chaining value
// would be, once the tail block (and for a full tail, the padding block) is
// through the engine.
// Reset clears control state; the key memory holds nothing useful until the
// first message expands it. A stalled receiver holds the MAC in the output
// register; body blocks are still taken while the MAC waits, but a tail beat
// is held off until the earlier MAC is taken.
module sm4_cbc_mac_unit import sm4mac_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // data_high[63:0], data_low[127:64], valid_bytes[132:128]
  input  logic         in_tlast,   // last
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // mac_high[63:0], mac_low[127:64]
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_PAD} state_t;

  logic [63:0] key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic [127:0] cv_r, keyl_r;
  logic in_msg_r, last_r, out_valid_r;
  logic [127:0] out_r;
  state_t state_r;
  // remembers that a full tail still owes a padding block
  logic full_pend_r;

  logic go, expand, done;
  logic [127:0] blk, res, tail, pad_mask, data_in;
  logic [4:0] n;

  // config
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0; key_lo_r <= '0; iv_hi_r <= '0; iv_lo_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[4:3])
        2'd0: key_hi_r <= cfg_pwdata;
        2'd1: key_lo_r <= cfg_pwdata;
        2'd2: iv_hi_r  <= cfg_pwdata;
        2'd3: iv_lo_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end
  always_comb begin
    case (cfg_paddr[4:3])
      2'd0: cfg_prdata = key_hi_r;
      2'd1: cfg_prdata = key_lo_r;
      2'd2: cfg_prdata = iv_hi_r;
      default: cfg_prdata = iv_lo_r;
    endcase
  end

  // tail masking: keep bytes below n, XOR 0x80 at byte n (big-endian order)
  assign data_in = {in_tdata[63:0], in_tdata[127:64]};
  assign n = (in_tdata[132:128] > BlockBytes) ? BlockBytes : in_tdata[132:128];
  always_comb begin
    pad_mask = '0;
    tail = '0;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) < n) tail[127-8*i -: 8] = data_in[127-8*i -: 8];
      if (5'(i) == n) pad_mask[127-8*i -: 8] = PadByte;
    end
  end

  wire in_fire = in_tvalid && in_tready;
  wire full_tail = in_tlast && (n == BlockBytes);
  wire [127:0] cv_src = in_msg_r ? cv_r : {iv_hi_r, iv_lo_r};

  assign in_tready = (state_r == T_IDLE) && !(out_valid_r && in_tlast);
  assign go = in_fire || (state_r == T_PAD);
  assign expand = in_fire && !in_msg_r;
  assign blk = (state_r == T_PAD) ? (cv_r ^ {PadByte, 120'd0}) :
               (!in_tlast || full_tail) ? (cv_src ^ data_in) :
               (cv_src ^ tail ^ pad_mask);

  always_ff @(posedge clk) begin
    if (in_fire && !in_msg_r) keyl_r <= {key_hi_r, key_lo_r};
  end

  sm4mac_core u_core (
    .clk, .rst_n, .go, .expand,
    .key(expand ? {key_hi_r, key_lo_r} : keyl_r),
    .blk, .done, .res
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      in_msg_r <= 1'b0;
      last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        T_IDLE: begin
          if (in_fire) begin
            in_msg_r <= 1'b1;
            last_r <= in_tlast;
            state_r <= T_RUN;
          end
        end
        T_RUN: begin
          if (done) begin
            cv_r <= res;
            if (last_r && full_pend_r) begin
              state_r <= T_PAD;
            end else begin
              state_r <= T_IDLE;
              if (last_r) begin
                out_r <= res;
                out_valid_r <= 1'b1;
                in_msg_r <= 1'b0;
              end
            end
          end
        end
        T_PAD: begin
          state_r <= T_RUN;
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_pend_r <= 1'b0;
    end else if (in_fire) begin
      full_pend_r <= full_tail;
    end else if (state_r == T_PAD) begin
      full_pend_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r[63:0], out_r[127:64]};

endmodule

>>> rtl/core/sm4mac_core.sv
// SM4 round engine: key expansion and encryption, round keys held in a memory.
module sm4mac_core import sm4mac_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,        // start one block
  input  logic         expand,    // run key schedule before the block
  input  logic [127:0] key,
  input  logic [127:0] blk,
  output logic         done,
  output logic [127:0] res
);

  typedef enum logic [1:0] {S_IDLE, S_KEY, S_PRE, S_ENC} state_t;

  logic [31:0] rk_mem [Rounds];
  logic [31:0] rk_rd_r;
  state_t      state_r;
  logic [RkAw-1:0] cnt_r;
  logic [31:0] x0_r, x1_r, x2_r, x3_r;
  logic [127:0] blk_r;
  logic        done_r;

  logic [31:0] knew, xnew;
  logic [RkAw-1:0] rd_addr;
  logic        wr_en;

  assign knew = x0_r ^ key_lin(x1_r ^ x2_r ^ x3_r ^ ck_word(cnt_r));
  assign xnew = x0_r ^ round_lin(x1_r ^ x2_r ^ x3_r ^ rk_rd_r);
  assign wr_en = (state_r == S_KEY);
  assign rd_addr = (state_r == S_ENC) ? cnt_r + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rk_mem[cnt_r] <= knew;
    end
    rk_rd_r <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (go) begin
            blk_r <= blk;
            cnt_r <= '0;
            if (expand) begin
              {x0_r, x1_r, x2_r, x3_r} <= key ^ {FK0, FK1, FK2, FK3};
              state_r <= S_KEY;
            end else begin
              state_r <= S_PRE;
            end
          end
        end
        S_KEY: begin
          {x0_r, x1_r, x2_r, x3_r} <= {x1_r, x2_r, x3_r, knew};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == RkAw'(Rounds - 1)) begin
            state_r <= S_PRE;
          end
        end
        S_PRE: begin
          // round key 0 read is in flight
          {x0_r, x1_r, x2_r, x3_r} <= blk_r;
          cnt_r <= '0;
          state_r <= S_ENC;
        end
        S_ENC: begin
          {x0_r, x1_r, x2_r, x3_r} <= {x1_r, x2_r, x3_r, xnew};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == RkAw'(Rounds - 1)) begin
            state_r <= S_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = {x3_r, x2_r, x1_r, x0_r};

endmodule

>>> rtl/core/sm4mac_chk.sv
// Port checker for the SM4 CBC-MAC unit, bound to the top level.
module sm4mac_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  a_no_mac_wo_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready && !in_tlast))
    else $error("result without last beat");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second beat taken during a block");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind sm4_cbc_mac_unit sm4mac_chk u_chk (
  .clk, .rst_n, .in_tvalid, .in_tready, .in_tlast,
  .out_tvalid, .out_tready, .out_tdata
);

>>> dv/sm4_cbc_mac_unit_tb.sv
// Testbench for the SM4 CBC-MAC unit: scoreboard against an in-bench SM4 predictor.
`timescale 1ns / 100ps

module sm4_cbc_mac_unit_tb;
  import sm4mac_pkg::*;

  typedef enum logic [4:0] {
    REG_KEY_HIGH = 5'h00,
    REG_KEY_LOW  = 5'h08,
    REG_IV_HIGH  = 5'h10,
    REG_IV_LOW   = 5'h18
  } mac_reg_e;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam logic [7:0] MAC_PAD = 8'h80;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;   // data_high[63:0], data_low[127:64], valid_bytes[132:128]
  logic         in_tlast;   // last
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // mac_high[63:0], mac_low[127:64]
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [63:0]  cfg_pwdata;
  logic [63:0]  cfg_prdata;
  logic         cfg_pready;

  sm4_cbc_mac_unit dut (.*);

  logic [7:0] sm4_sbox [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // predictor state
  logic [63:0]  mdl_key_hi, mdl_key_lo, mdl_iv_hi, mdl_iv_lo;
  logic [127:0] mdl_chain;
  logic [31:0]  mdl_rk [32];
  bit           mdl_in_msg;

  logic [127:0] mac_queue [$];
  int           err_cnt;
  int           send_idle_pct, recv_idle_pct;
  int           hold_left;
  int unsigned  stall_cnt;

  function automatic logic [31:0] sub_word(logic [31:0] a);
    return {sm4_sbox[a[31:24]], sm4_sbox[a[23:16]], sm4_sbox[a[15:8]], sm4_sbox[a[7:0]]};
  endfunction

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [31:0] mix_data(logic [31:0] a);
    logic [31:0] b;
    b = sub_word(a);
    return b ^ rol32(b, 2) ^ rol32(b, 10) ^ rol32(b, 18) ^ rol32(b, 24);
  endfunction

  function automatic logic [31:0] mix_key(logic [31:0] a);
    logic [31:0] b;
    b = sub_word(a);
    return b ^ rol32(b, 13) ^ rol32(b, 23);
  endfunction

  task automatic schedule_keys();
    logic [31:0] k [4];
    logic [31:0] ck, nk;
    k[0] = mdl_key_hi[63:32] ^ 32'ha3b1bac6;
    k[1] = mdl_key_hi[31:0]  ^ 32'h56aa3350;
    k[2] = mdl_key_lo[63:32] ^ 32'h677d9197;
    k[3] = mdl_key_lo[31:0]  ^ 32'hb27022dc;
    for (int i = 0; i < 32; i++) begin
      for (int j = 0; j < 4; j++) ck[31-8*j -: 8] = 8'((4*i + j) * 7);
      nk = k[0] ^ mix_key(k[1] ^ k[2] ^ k[3] ^ ck);
      mdl_rk[i] = nk;
      k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = nk;
    end
  endtask

  function automatic logic [127:0] sm4_encrypt(logic [127:0] blk);
    logic [31:0] x [4];
    logic [31:0] nx;
    x[0] = blk[127:96]; x[1] = blk[95:64]; x[2] = blk[63:32]; x[3] = blk[31:0];
    for (int i = 0; i < 32; i++) begin
      nx = x[0] ^ mix_data(x[1] ^ x[2] ^ x[3] ^ mdl_rk[i]);
      x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = nx;
    end
    return {x[3], x[2], x[1], x[0]};
  endfunction

  // advance the MAC predictor by one accepted block; queue the MAC on the tail
  task automatic predict_mac(logic [63:0] dh, logic [63:0] dl, logic [4:0] nb, bit last);
    logic [127:0] blk;
    int n;
    blk = {dh, dl};
    if (!mdl_in_msg) begin
      schedule_keys();
      mdl_chain = {mdl_iv_hi, mdl_iv_lo};
      mdl_in_msg = 1;
    end
    if (!last) begin
      mdl_chain = sm4_encrypt(mdl_chain ^ blk);
    end else begin
      n = (nb > 16) ? 16 : nb;
      if (n == 16) begin
        // full tail: ordinary block, then a pad-only block
        mdl_chain = sm4_encrypt(mdl_chain ^ blk);
        mdl_chain[127:120] ^= MAC_PAD;
      end else begin
        for (int i = 0; i < n; i++) mdl_chain[127-8*i -: 8] ^= blk[127-8*i -: 8];
        mdl_chain[127-8*n -: 8] ^= MAC_PAD;
      end
      mdl_chain = sm4_encrypt(mdl_chain);
      mac_queue.push_back(mdl_chain);
      mdl_in_msg = 0;
    end
  endtask

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (mac_queue.size() == 0) begin
        $error("unexpected MAC beat %h", out_tdata);
        err_cnt++;
      end else begin
        if (out_tdata[63:0] !== mac_queue[0][127:64]) begin
          $error("mac_high: expected %h, got %h", mac_queue[0][127:64], out_tdata[63:0]);
          err_cnt++;
        end
        if (out_tdata[127:64] !== mac_queue[0][63:0]) begin
          $error("mac_low: expected %h, got %h", mac_queue[0][63:0], out_tdata[127:64]);
          err_cnt++;
        end
        void'(mac_queue.pop_front());
      end
    end
  end

  // receiver: random stalls plus a long hold-off in the backpressure test
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  task automatic send_block(logic [63:0] dh, logic [63:0] dl, logic [4:0] nb, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, nb, dl, dh};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_mac(dh, dl, nb, last);
  endtask

  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    idle_input();
    while (mac_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(mac_reg_e addr, logic [63:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (addr)
      REG_KEY_HIGH: mdl_key_hi = value;
      REG_KEY_LOW:  mdl_key_lo = value;
      REG_IV_HIGH:  mdl_iv_hi  = value;
      default:      mdl_iv_lo  = value;
    endcase
  endtask

  task automatic set_keys(logic [63:0] kh, logic [63:0] kl, logic [63:0] ih, logic [63:0] il);
    write_reg(REG_KEY_HIGH, kh);
    write_reg(REG_KEY_LOW, kl);
    write_reg(REG_IV_HIGH, ih);
    write_reg(REG_IV_LOW, il);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_keys(64'h0123456789abcdef, 64'hfedcba9876543210, '0, '0);
    send_block('0, '0, 5'd0, 1);                              // empty message
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 5'd16, 1); // full tail
    send_block('1, '1, 5'd1, 1);
    send_block('1, '1, 5'd7, 1);
    send_block('1, '1, 5'd8, 1);
    send_block('1, '1, 5'd15, 1);
    send_block(rnd64(), rnd64(), 5'd17, 1);                   // oversized tail
    send_block(rnd64(), rnd64(), 5'd31, 1);
    // multi-block messages, valid_bytes on body beats is don't-care
    send_block('1, '0, 5'd31, 0);
    send_block('0, '1, 5'd0, 0);
    send_block(rnd64(), rnd64(), 5'd3, 1);
    send_block(rnd64(), rnd64(), 5'd16, 0);
    send_block(rnd64(), rnd64(), 5'd16, 1);
    drain();
    set_keys('1, '1, '1, '1);
    send_block('1, '1, 5'd16, 1);
    send_block('0, '0, 5'd9, 0);
    send_block('1, '1, 5'd12, 1);
    drain();
    set_keys('0, '0, '0, '0);
    send_block('0, '0, 5'd0, 1);
    send_block('0, '0, 5'd16, 1);
    drain();
  endtask

  task automatic send_message(int blocks);
    for (int b = 0; b < blocks - 1; b++)
      send_block(rnd64(), rnd64(), 5'($urandom_range(31)), 0);
    send_block(rnd64(), rnd64(),
               5'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(16)), 1);
  endtask

  task automatic test_random(int n_blocks, int s_idle, int r_idle);
    int sent, len;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    set_keys(rnd64(), rnd64(), rnd64(), rnd64());
    sent = 0;
    while (sent < n_blocks) begin
      len = ($urandom_range(3) == 0) ? 1 : $urandom_range(6, 1);
      send_message(len);
      sent += len;
    end
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_left <= 600;
    for (int m = 0; m < 6; m++) send_message(1);
    drain();
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0; in_tdata = '0; in_tlast = 0;
    out_tready = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = '0; cfg_pwdata = '0;
    err_cnt = 0; hold_left = 0; stall_cnt = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    mdl_key_hi = '0; mdl_key_lo = '0; mdl_iv_hi = '0; mdl_iv_lo = '0;
    mdl_chain = '0; mdl_in_msg = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(140, 35, 64);
    test_random(140, 64, 35);
    test_random(140, 0, 0);
    test_backpressure();
    if (err_cnt == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
